// ----- rtl/tfst_pkg.sv -----
// ----------------------------------------------------------------------------
// tfst_pkg
// Shared types and constants for the TCP flow state tracker: request,
// response and table entry layouts, controller command bundle, TCP state
// and flag codes.
// ----------------------------------------------------------------------------
package tfst_pkg;

   localparam int FLOW_SLOTS = 1024;
   localparam int SLOT_W     = $clog2(FLOW_SLOTS);

   localparam logic [2:0] TS_CLOSED    = 3'd0;
   localparam logic [2:0] TS_SYN_SENT  = 3'd1;
   localparam logic [2:0] TS_SYN_RCVD  = 3'd2;
   localparam logic [2:0] TS_ESTAB     = 3'd3;
   localparam logic [2:0] TS_FIN_WAIT1 = 3'd4;
   localparam logic [2:0] TS_TIME_WAIT = 3'd5;

   localparam logic [7:0] FL_FIN    = 8'h01;
   localparam logic [7:0] FL_SYN    = 8'h02;
   localparam logic [7:0] FL_RST    = 8'h04;
   localparam logic [7:0] FL_ACK    = 8'h10;
   localparam logic [7:0] FL_SYNACK = 8'h12;
   localparam logic [7:0] FL_FINACK = 8'h11;

   localparam logic [31:0] MAX32      = 32'hFFFF_FFFF;
   localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;
   localparam logic [10:0] ACTIVE_MAX = 11'h7FF;

   typedef struct packed {
      logic [9:0]  flow_slot;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic        has_tcp;
      logic [7:0]  flag_bits;
      logic [31:0] seq_num;
      logic [31:0] ack_num;
      logic [15:0] pkt_len;
   } req_type;

   typedef struct packed {
      logic        new_entry;
      logic [2:0]  conn_st;
      logic        state_changed;
      logic        went_closed;
      logic        reset_alert;
      logic        retransmit_seen;
      logic        flow_active;
      logic        is_forward;
      logic [31:0] flow_packet_count;
      logic [47:0] flow_byte_count;
      logic [31:0] flow_retx_count;
      logic [10:0] active_flow_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key_ip;
      logic [15:0] key_port;
      logic [2:0]  conn_st;
      logic        active;
      logic [31:0] fwd_seq;
      logic [31:0] rev_seq;
      logic [31:0] last_ack;
      logic [31:0] packets;
      logic [47:0] bytes;
      logic [31:0] retx;
   } entry_type;

   typedef struct packed {
      logic              capture;
      logic              exec;
      logic              clear;
      logic [SLOT_W-1:0] clr_addr;
   } cmd_type;

endpackage

// ----- rtl/tcp_flow_state_tracker.sv -----
// The result strobe rises once an accepted beat has passed the capture and EXEC states.
// A new beat is accepted only after the last one leaves EXEC: flow table read, then write-back.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset: a sweep clears all 1024 flow table slots; busy is high until it ends.
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker
// Per-flow TCP tracker: flow creation, saturating counters, retransmit
// detection and TCP state stepping over a slot-indexed flow table.
// ----------------------------------------------------------------------------
module tcp_flow_state_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tfst_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tfst_pkg::rsp_type rsp_data
);
   import tfst_pkg::*;

   cmd_type cmd;

   tfst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   tfst_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted beat gave no result");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("not busy after accept");

   a_closed_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.went_closed) |->
         (!rsp_data.flow_active && rsp_data.state_changed &&
          (rsp_data.conn_st == TS_CLOSED)))
      else $error("closed flow left active or state unchanged");
`endif

endmodule

// ----- rtl/tfst_ctrl.sv -----
// ----------------------------------------------------------------------------
// tfst_ctrl
// Controller: table clear sweep after reset, beat accept, the execute
// state for each beat and the response strobe.
// ----------------------------------------------------------------------------
module tfst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_strobe,
   output tfst_pkg::cmd_type cmd
);
   import tfst_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } ctrl_state_type;

   ctrl_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] clr_addr_ff, clr_addr_in;
   logic              strobe_ff, strobe_in;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      strobe_in   = 1'b0;
      cmd         = '0;
      cmd.clr_addr = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear   = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == SLOT_W'(FLOW_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec  = 1'b1;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         strobe_ff   <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ----- rtl/tfst_datapath.sv -----
// ----------------------------------------------------------------------------
// tfst_datapath
// Flow table memory, request register, per-packet entry update
// (create, counters, retransmit check, TCP state step) and active count.
// ----------------------------------------------------------------------------
module tfst_datapath (
   input  logic              clock,
   input  logic              reset,
   input  tfst_pkg::cmd_type cmd,
   input  tfst_pkg::req_type req_data,
   output tfst_pkg::rsp_type rsp_data
);
   import tfst_pkg::*;

   entry_type flow_mem [FLOW_SLOTS];

   req_type   req_ff;
   entry_type rd_ff;
   rsp_type   rsp_ff, rsp_in;
   logic [10:0] active_cnt_ff, active_cnt_in;
   entry_type upd;

   logic [SLOT_W-1:0] rd_idx;
   logic [SLOT_W-1:0] wr_idx;

   assign rd_idx = req_data.flow_slot[SLOT_W-1:0];
   assign wr_idx = req_ff.flow_slot[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         flow_mem[cmd.clr_addr] <= '0;
      end else if (cmd.exec) begin
         flow_mem[wr_idx] <= upd;
      end
      if (cmd.capture) begin
         rd_ff  <= flow_mem[rd_idx];
         req_ff <= req_data;
      end
   end

   always_comb begin
      entry_type   base;
      logic        created;
      logic        lower_src;
      logic        fwd;
      logic [48:0] byte_sum;
      logic [31:0] prev_seq;
      logic        seq_chk;
      logic        retx;
      logic [2:0]  old_st;
      logic [2:0]  nxt_st;
      logic [2:0]  new_st;
      logic        changed;
      logic        closed;
      logic        dec;
      logic [10:0] cnt_mid;

      created   = !rd_ff.valid;
      lower_src = (req_ff.src_ip < req_ff.dst_ip) ||
                  ((req_ff.src_ip == req_ff.dst_ip) && (req_ff.sport <= req_ff.dport));
      base      = rd_ff;
      byte_sum  = {1'b0, rd_ff.bytes} + 49'(req_ff.pkt_len);
      if (created) begin
         base.valid     = 1'b1;
         base.key_ip    = lower_src ? req_ff.src_ip : req_ff.dst_ip;
         base.key_port  = lower_src ? req_ff.sport  : req_ff.dport;
         base.conn_st   = TS_CLOSED;
         base.active    = 1'b1;
         base.fwd_seq   = '0;
         base.rev_seq   = '0;
         base.last_ack  = '0;
         base.packets   = 32'd1;
         base.bytes     = 48'(req_ff.pkt_len);
         base.retx      = '0;
         fwd            = lower_src;
      end else begin
         if (rd_ff.packets != MAX32) begin
            base.packets = rd_ff.packets + 1'b1;
         end
         base.bytes = byte_sum[48] ? MAX48 : byte_sum[47:0];
         fwd        = (req_ff.src_ip == rd_ff.key_ip) && (req_ff.sport == rd_ff.key_port);
      end

      upd      = base;
      prev_seq = fwd ? base.fwd_seq : base.rev_seq;
      seq_chk  = req_ff.has_tcp && (req_ff.seq_num != '0);
      retx     = seq_chk && (prev_seq != '0) && (req_ff.seq_num <= prev_seq) &&
                 (req_ff.flag_bits != FL_ACK);
      if (retx && (base.retx != MAX32)) begin
         upd.retx = base.retx + 1'b1;
      end
      if (seq_chk && (req_ff.seq_num > prev_seq)) begin
         if (fwd) begin
            upd.fwd_seq = req_ff.seq_num;
         end else begin
            upd.rev_seq = req_ff.seq_num;
         end
      end

      old_st = base.conn_st;
      if ((req_ff.flag_bits & FL_RST) != '0) begin
         nxt_st = TS_CLOSED;
      end else if ((old_st == TS_CLOSED) && ((req_ff.flag_bits & FL_SYN) != '0)) begin
         nxt_st = TS_SYN_SENT;
      end else if ((old_st == TS_SYN_SENT) && ((req_ff.flag_bits & FL_SYNACK) == FL_SYNACK)) begin
         nxt_st = TS_SYN_RCVD;
      end else if ((old_st == TS_SYN_RCVD) && ((req_ff.flag_bits & FL_ACK) != '0)) begin
         nxt_st = TS_ESTAB;
      end else if ((old_st == TS_CLOSED) && ((req_ff.flag_bits & FL_ACK) != '0)) begin
         nxt_st = TS_ESTAB;
      end else if ((old_st == TS_ESTAB) && ((req_ff.flag_bits & FL_FIN) != '0)) begin
         nxt_st = TS_FIN_WAIT1;
      end else if ((old_st == TS_FIN_WAIT1) &&
                   ((req_ff.flag_bits & FL_FINACK) == FL_FINACK)) begin
         nxt_st = TS_TIME_WAIT;
      end else begin
         nxt_st = old_st;
      end
      new_st        = req_ff.has_tcp ? nxt_st : old_st;
      upd.conn_st   = new_st;
      changed       = (new_st != old_st);
      closed        = changed && (new_st == TS_CLOSED);
      dec           = closed && base.active && (active_cnt_ff != '0);
      if (closed) begin
         upd.active = 1'b0;
      end
      if (req_ff.has_tcp && (req_ff.ack_num > base.last_ack)) begin
         upd.last_ack = req_ff.ack_num;
      end

      cnt_mid       = dec ? (active_cnt_ff - 1'b1) : active_cnt_ff;
      active_cnt_in = (created && (cnt_mid != ACTIVE_MAX)) ? (cnt_mid + 1'b1) : cnt_mid;

      rsp_in.new_entry         = created;
      rsp_in.conn_st           = new_st;
      rsp_in.state_changed     = changed;
      rsp_in.went_closed       = closed;
      rsp_in.reset_alert       = req_ff.has_tcp && ((req_ff.flag_bits & FL_RST) != '0);
      rsp_in.retransmit_seen   = retx;
      rsp_in.flow_active       = upd.active;
      rsp_in.is_forward        = fwd;
      rsp_in.flow_packet_count = upd.packets;
      rsp_in.flow_byte_count   = upd.bytes;
      rsp_in.flow_retx_count   = upd.retx;
      rsp_in.active_flow_count = active_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_cnt_ff <= '0;
      end else if (cmd.exec) begin
         active_cnt_ff <= active_cnt_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
